### design/imse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imse_pkg
// Shared widths, command/status types and controller states for the image
// mean square error block.
// ----------------------------------------------------------------------------
package imse_pkg;

   localparam int PIXEL_BITS      = 8;
   localparam int MAX_PIXELS_LOG2 = 20;

   // Field widths of the transactions
   localparam int PIX_W = 8;
   localparam int MSE_W = 16;

   // Accumulator widths: the count can reach 2^MAX_PIXELS_LOG2 itself
   localparam int SQUARE_W = 2 * PIXEL_BITS;
   localparam int COUNT_W  = MAX_PIXELS_LOG2 + 1;
   localparam int SUM_W    = SQUARE_W + MAX_PIXELS_LOG2;
   localparam int STEP_W   = $clog2(SUM_W);

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_FINISH
   } imse_state_type;

   typedef struct packed {
      logic accum_en;
      logic div_init;
      logic div_step;
      logic result_load;
   } imse_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } imse_status_type;

endpackage

`default_nettype wire

### design/imse_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imse_req_if
// Pixel pair channel: valid/ready handshake with one pixel pair per
// transaction.
// ----------------------------------------------------------------------------
interface imse_req_if;
   import imse_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_orig;
   logic [PIX_W-1:0] pixel_recon;
   logic             last_pixel;

   modport source (output valid, output pixel_orig, output pixel_recon,
                   output last_pixel, input ready);
   modport sink   (input valid, input pixel_orig, input pixel_recon,
                   input last_pixel, output ready);
endinterface

`default_nettype wire

### design/imse_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imse_rsp_if
// Result channel: valid/ready handshake carrying one mean square error per
// transaction.
// ----------------------------------------------------------------------------
interface imse_rsp_if;
   import imse_pkg::*;

   logic             valid;
   logic             ready;
   logic [MSE_W-1:0] mse;
   logic             overflow;

   modport source (output valid, output mse, output overflow, input ready);
   modport sink   (input valid, input mse, input overflow, output ready);
endinterface

`default_nettype wire

### design/imse_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imse_ctrl
// Controller: accumulate pixel pairs, run the serial divider on the last
// pair, then hand the result to the output register.
// ----------------------------------------------------------------------------
module imse_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   input  wire                        req_last,
   output logic                       req_ready,
   input  imse_pkg::imse_status_type  status,
   output imse_pkg::imse_cmd_type     cmd
);
   import imse_pkg::*;

   imse_state_type state_ff;
   imse_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_ACCUM: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum_en = 1'b1;
               if (req_last) begin
                  state_in = ST_DIV_INIT;
               end
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait until the output register can take the result
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/imse_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imse_dpath
// Datapath: squared difference accumulator, pixel counter, restoring
// divider (one quotient bit per cycle) and the result register.
// ----------------------------------------------------------------------------
module imse_dpath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [imse_pkg::PIX_W-1:0]          req_pixel_orig,
   input  wire  [imse_pkg::PIX_W-1:0]          req_pixel_recon,
   input  imse_pkg::imse_cmd_type              cmd,
   output imse_pkg::imse_status_type           status,
   input  wire                                 rsp_ready,
   output logic                                rsp_valid,
   output logic [imse_pkg::MSE_W-1:0]          rsp_mse,
   output logic                                rsp_overflow
);
   import imse_pkg::*;

   logic [PIXEL_BITS-1:0] pix_a;
   logic [PIXEL_BITS-1:0] pix_b;
   logic [PIXEL_BITS-1:0] diff;
   logic [SQUARE_W-1:0]   square;
   logic                  count_full;

   logic [SUM_W-1:0]   sum_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               ovf_ff;

   logic [SUM_W-1:0]   quo_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [COUNT_W:0]   rem_shift;
   logic [COUNT_W:0]   rem_trial;
   logic               quo_bit;
   logic [MSE_W-1:0]   mse_sat;

   logic               rsp_valid_ff;
   logic [MSE_W-1:0]   mse_ff;
   logic               overflow_ff;

   assign pix_a = req_pixel_orig[PIXEL_BITS-1:0];
   assign pix_b = req_pixel_recon[PIXEL_BITS-1:0];
   assign diff = (pix_a >= pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
   assign square = SQUARE_W'(diff) * SQUARE_W'(diff);
   assign count_full = count_ff[MAX_PIXELS_LOG2];

   // Accumulators; cleared when the result of the image is loaded into the output register
   always_ff @(posedge clock) begin
      if (reset || cmd.result_load) begin
         sum_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.accum_en) begin
         if (count_full) begin
            ovf_ff <= 1'b1;
         end else begin
            sum_ff <= sum_ff + SUM_W'(square);
            count_ff <= count_ff + COUNT_W'(1);
         end
      end
   end

   // Restoring division of sum_ff by count_ff, MSB first
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_trial = rem_shift - {1'b0, count_ff};
   assign quo_bit = (rem_shift >= {1'b0, count_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         quo_ff <= sum_ff;
         rem_ff <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], quo_bit};
         rem_ff <= quo_bit ? rem_trial[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   assign mse_sat = (|quo_ff[SUM_W-1:MSE_W]) ? {MSE_W{1'b1}} : quo_ff[MSE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         mse_ff <= mse_sat;
         overflow_ff <= ovf_ff;
      end
   end

   assign status.div_last = (step_ff == STEP_W'(SUM_W - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mse = mse_ff;
   assign rsp_overflow = overflow_ff;

endmodule

`default_nettype wire

### design/image_mean_square_error_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_mean_square_error_top
// Streams co-located pixel pairs of two images and returns the mean square
// error on the pair marked last.
// ----------------------------------------------------------------------------
// Pixel pairs are taken one per clock cycle while an image is being summed.
// The pair marked last is summed too and starts a restoring divider that
// produces one quotient bit per cycle over the 36-bit sum. No pair is taken
// while the controller is in ST_DIV_INIT, ST_DIVIDE or ST_FINISH; the result
// is loaded into the output register once ST_FINISH finds it free, and the
// next image's first pair can be accepted in the cycle after. A result that
// is still waiting in the output register does not stop the next image from
// being summed; only the next result load waits for it. Images of more than
// 2^20 pairs keep the mean over the first 2^20 and flag overflow.
module image_mean_square_error_top (
   input wire           clock,
   input wire           reset,
   imse_req_if.sink     req_if,
   imse_rsp_if.source   rsp_if
);
   import imse_pkg::*;

   imse_cmd_type    cmd;
   imse_status_type status;

   imse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_pixel),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   imse_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_pixel_orig  (req_if.pixel_orig),
      .req_pixel_recon (req_if.pixel_recon),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_mse         (rsp_if.mse),
      .rsp_overflow    (rsp_if.overflow)
   );

endmodule

`default_nettype wire
